@@ hw/rtl/aqic_pkg.sv @@
`default_nettype none

package aqic_pkg;

    // fixed-point format of levels and indices
    localparam int FRAC_BITS = 4;
    localparam int SCALE     = 1 << FRAC_BITS;

    // field widths
    localparam int CO2_W   = 18;
    localparam int GAS_W   = 14;
    localparam int IDX_W   = 12;
    localparam int CAT_W   = 3;
    localparam int ALERT_W = 2;

    // datapath widths: XS_W holds a level or ten times a PM2.5 level,
    // NUM_W the rounded numerator, REC_W a reciprocal, QUO_W a quotient
    localparam int XS_W  = 18;
    localparam int NUM_W = FRAC_BITS + 16;
    localparam int REC_W = NUM_W - 5;
    localparam int QUO_W = NUM_W - 5;
    localparam int DEN_W = 10;
    localparam longint RECIP_ONE = longint'(1) << NUM_W;
    localparam int IDX_MAX = (1 << IDX_W) - 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CO2_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CO2_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SO2_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO2_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PM25_LIMIT = 2'd3;

    localparam logic [CO2_W-1:0] CO2_LIMIT_RST  = 18'd16000;
    localparam logic [GAS_W-1:0] SO2_LIMIT_RST  = 14'd640;
    localparam logic [GAS_W-1:0] NO2_LIMIT_RST  = 14'd400;
    localparam logic [GAS_W-1:0] PM25_LIMIT_RST = 14'd240;

    // fixed alert thresholds
    localparam logic [CO2_W-1:0] CO2_LOW_FROM  = CO2_W'(400 * SCALE);
    localparam logic [CO2_W-1:0] CO2_MED_ABOVE = CO2_W'(800 * SCALE);
    localparam logic [GAS_W-1:0] SO2_MED_FROM  = GAS_W'(21 * SCALE);
    localparam logic [GAS_W-1:0] NO2_MED_FROM  = GAS_W'(14 * SCALE);
    localparam logic [GAS_W-1:0] PM25_MED_FROM = GAS_W'(8 * SCALE);

    // alert codes
    localparam logic [ALERT_W-1:0] CO2_ALERT_VERY_LOW = 2'd0;
    localparam logic [ALERT_W-1:0] CO2_ALERT_LOW      = 2'd1;
    localparam logic [ALERT_W-1:0] CO2_ALERT_MEDIUM   = 2'd2;
    localparam logic [ALERT_W-1:0] CO2_ALERT_HIGH     = 2'd3;
    localparam logic [ALERT_W-1:0] GAS_ALERT_LOW      = 2'd0;
    localparam logic [ALERT_W-1:0] GAS_ALERT_MEDIUM   = 2'd1;
    localparam logic [ALERT_W-1:0] GAS_ALERT_HIGH     = 2'd2;

    // index categories
    localparam logic [CAT_W-1:0] CAT_GOOD           = 3'd0;
    localparam logic [CAT_W-1:0] CAT_MODERATE       = 3'd1;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE      = 3'd2;
    localparam logic [CAT_W-1:0] CAT_UNHEALTHY      = 3'd3;
    localparam logic [CAT_W-1:0] CAT_VERY_UNHEALTHY = 3'd4;
    localparam logic [CAT_W-1:0] CAT_HAZARDOUS      = 3'd5;

    typedef enum logic [1:0] {POL_CO2, POL_SO2, POL_NO2, POL_PM25} pollutant_t;
    typedef enum logic [1:0] {SEG_LOW, SEG_MID, SEG_HIGH, SEG_TOP} seg_t;

    typedef struct packed {
        logic [CO2_W-1:0] co2_level;
        logic [GAS_W-1:0] so2_level;
        logic [GAS_W-1:0] no2_level;
        logic [GAS_W-1:0] pm25_level;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   co2_index;
        logic [IDX_W-1:0]   so2_index;
        logic [IDX_W-1:0]   no2_index;
        logic [IDX_W-1:0]   pm25_index;
        logic [CAT_W-1:0]   co2_category;
        logic [CAT_W-1:0]   so2_category;
        logic [CAT_W-1:0]   no2_category;
        logic [CAT_W-1:0]   pm25_category;
        logic [ALERT_W-1:0] co2_alert_level;
        logic [ALERT_W-1:0] so2_alert_level;
        logic [ALERT_W-1:0] no2_alert_level;
        logic [ALERT_W-1:0] pm25_alert_level;
    } out_item_t;

    typedef struct packed {
        logic [ALERT_W-1:0] co2;
        logic [ALERT_W-1:0] so2;
        logic [ALERT_W-1:0] no2;
        logic [ALERT_W-1:0] pm25;
    } alerts_t;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic so;
    } adv_t;

    // one line segment: base*S*den, start offset, divisor, reciprocal, slope flag
    typedef struct packed {
        logic [NUM_W-1:0] bterm;
        logic [XS_W-1:0]  off;
        logic [DEN_W-1:0] den;
        logic [REC_W-1:0] recip;
        logic             slope;
    } seg_info_t;

    typedef struct packed {
        logic [XS_W-1:0] h1;
        logic [XS_W-1:0] h2;
        logic [XS_W-1:0] h3;
    } seg_bounds_t;

    function automatic seg_info_t seg_entry(input int base, input int off, input int den,
                                            input longint recip, input logic slope);
        seg_info_t e;
        e.bterm = NUM_W'(base * SCALE * den);
        e.off   = XS_W'(off * SCALE);
        e.den   = DEN_W'(den);
        e.recip = REC_W'(recip);
        e.slope = slope;
        return e;
    endfunction

    // top segment: no slope, numerator base*S*den so the quotient is base*S
    function automatic seg_info_t seg_lookup(input pollutant_t p, input seg_t s);
        seg_info_t e;
        case (p)
            POL_CO2:
                case (s)
                    SEG_LOW: e = seg_entry(0, 0, 800, RECIP_ONE / 800, 1'b1);
                    SEG_MID: e = seg_entry(50, 801, 199, RECIP_ONE / 199, 1'b1);
                    default: e = seg_entry(101, 0, 199, RECIP_ONE / 199, 1'b0);
                endcase
            POL_SO2:
                case (s)
                    SEG_LOW:  e = seg_entry(0, 0, 35, RECIP_ONE / 35, 1'b1);
                    SEG_MID:  e = seg_entry(50, 36, 39, RECIP_ONE / 39, 1'b1);
                    SEG_HIGH: e = seg_entry(100, 76, 109, RECIP_ONE / 109, 1'b1);
                    default:  e = seg_entry(151, 0, 35, RECIP_ONE / 35, 1'b0);
                endcase
            POL_NO2:
                case (s)
                    SEG_LOW:  e = seg_entry(0, 0, 53, RECIP_ONE / 53, 1'b1);
                    SEG_MID:  e = seg_entry(50, 54, 46, RECIP_ONE / 46, 1'b1);
                    SEG_HIGH: e = seg_entry(100, 101, 259, RECIP_ONE / 259, 1'b1);
                    default:  e = seg_entry(151, 0, 53, RECIP_ONE / 53, 1'b0);
                endcase
            default:
                // PM2.5 works on ten times the level
                case (s)
                    SEG_LOW:  e = seg_entry(0, 0, 120, RECIP_ONE / 120, 1'b1);
                    SEG_MID:  e = seg_entry(50, 121, 233, RECIP_ONE / 233, 1'b1);
                    SEG_HIGH: e = seg_entry(100, 355, 199, RECIP_ONE / 199, 1'b1);
                    default:  e = seg_entry(151, 0, 120, RECIP_ONE / 120, 1'b0);
                endcase
        endcase
        return e;
    endfunction

    // upper breakpoints; CO2 has only two segments, so h3 equals h2
    function automatic seg_bounds_t seg_bounds(input pollutant_t p);
        seg_bounds_t b;
        case (p)
            POL_CO2:
            begin
                b.h1 = XS_W'(800 * SCALE);
                b.h2 = XS_W'(1000 * SCALE);
                b.h3 = XS_W'(1000 * SCALE);
            end
            POL_SO2:
            begin
                b.h1 = XS_W'(35 * SCALE);
                b.h2 = XS_W'(75 * SCALE);
                b.h3 = XS_W'(185 * SCALE);
            end
            POL_NO2:
            begin
                b.h1 = XS_W'(53 * SCALE);
                b.h2 = XS_W'(100 * SCALE);
                b.h3 = XS_W'(360 * SCALE);
            end
            default:
            begin
                b.h1 = XS_W'(120 * SCALE);
                b.h2 = XS_W'(354 * SCALE);
                b.h3 = XS_W'(554 * SCALE);
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aqic_seg.sv @@
`default_nettype none

// segment select and rounded numerator for one pollutant
module aqic_seg #(
    parameter aqic_pkg::pollutant_t KIND = aqic_pkg::POL_CO2
) (
    input  logic [aqic_pkg::XS_W-1:0]  level,
    output logic [aqic_pkg::NUM_W-1:0] numer,
    output logic [aqic_pkg::REC_W-1:0] recip,
    output logic [aqic_pkg::DEN_W-1:0] den
);

    localparam aqic_pkg::seg_bounds_t BND = aqic_pkg::seg_bounds(KIND);

    logic [aqic_pkg::XS_W+3:0]          x10;
    logic [aqic_pkg::XS_W-1:0]          xs;
    aqic_pkg::seg_t                     seg;
    aqic_pkg::seg_info_t                info;
    logic signed [aqic_pkg::XS_W:0]     diff;
    logic signed [aqic_pkg::NUM_W+1:0]  diff_x;
    logic signed [aqic_pkg::NUM_W+1:0]  slope_term;
    logic signed [aqic_pkg::NUM_W+1:0]  num0;

    always_comb
    begin
        x10 = ({4'b0, level} << 3) + ({4'b0, level} << 1);
        xs  = (KIND == aqic_pkg::POL_PM25) ? x10[aqic_pkg::XS_W-1:0] : level;

        if (xs <= BND.h1)
            seg = aqic_pkg::SEG_LOW;
        else if (xs <= BND.h2)
            seg = aqic_pkg::SEG_MID;
        else if (xs <= BND.h3)
            seg = aqic_pkg::SEG_HIGH;
        else
            seg = aqic_pkg::SEG_TOP;

        info = aqic_pkg::seg_lookup(KIND, seg);

        // 50 * (xs - off), negative in the gap just past a breakpoint
        diff   = $signed({1'b0, xs}) - $signed({1'b0, info.off});
        diff_x = {{(aqic_pkg::NUM_W + 1 - aqic_pkg::XS_W){diff[aqic_pkg::XS_W]}}, diff};
        if (info.slope)
            slope_term = (diff_x <<< 5) + (diff_x <<< 4) + (diff_x <<< 1);
        else
            slope_term = '0;

        num0 = $signed({2'b0, info.bterm}) + slope_term;

        // clamp at zero, then add half the divisor for round-half-up
        if (num0[aqic_pkg::NUM_W+1])
            numer = aqic_pkg::NUM_W'(info.den >> 1);
        else
            numer = num0[aqic_pkg::NUM_W-1:0] + aqic_pkg::NUM_W'(info.den >> 1);

        recip = info.recip;
        den   = info.den;
    end

endmodule

`default_nettype wire

@@ hw/rtl/aqic_div.sv @@
`default_nettype none

// reciprocal divide, correction, saturation and category for one pollutant
module aqic_div (
    input  logic                       clk,
    input  aqic_pkg::adv_t             adv,
    input  logic [aqic_pkg::NUM_W-1:0] numer,
    input  logic [aqic_pkg::REC_W-1:0] recip,
    input  logic [aqic_pkg::DEN_W-1:0] den,
    output logic [aqic_pkg::IDX_W-1:0] index,
    output logic [aqic_pkg::CAT_W-1:0] category
);

    localparam int PROD_W = aqic_pkg::NUM_W + aqic_pkg::REC_W;
    localparam int BACK_W = aqic_pkg::QUO_W + aqic_pkg::DEN_W;
    localparam logic [aqic_pkg::QUO_W-1:0] CAT_B1 = aqic_pkg::QUO_W'(50 * aqic_pkg::SCALE);
    localparam logic [aqic_pkg::QUO_W-1:0] CAT_B2 = aqic_pkg::QUO_W'(100 * aqic_pkg::SCALE);
    localparam logic [aqic_pkg::QUO_W-1:0] CAT_B3 = aqic_pkg::QUO_W'(150 * aqic_pkg::SCALE);
    localparam logic [aqic_pkg::QUO_W-1:0] CAT_B4 = aqic_pkg::QUO_W'(200 * aqic_pkg::SCALE);
    localparam logic [aqic_pkg::QUO_W-1:0] CAT_B5 = aqic_pkg::QUO_W'(300 * aqic_pkg::SCALE);
    localparam logic [aqic_pkg::QUO_W-1:0] SAT_AT = aqic_pkg::QUO_W'(aqic_pkg::IDX_MAX);

    logic [aqic_pkg::NUM_W-1:0] numer1_reg, numer2_reg;
    logic [aqic_pkg::REC_W-1:0] recip1_reg;
    logic [aqic_pkg::DEN_W-1:0] den1_reg, den2_reg;
    logic [aqic_pkg::QUO_W-1:0] quo2_reg, quo3_reg;
    logic                       bump3_reg;
    logic [aqic_pkg::IDX_W-1:0] index_reg;
    logic [aqic_pkg::CAT_W-1:0] category_reg;

    logic [PROD_W-1:0]          prod;
    logic [aqic_pkg::QUO_W-1:0] quo2_next;
    logic [BACK_W-1:0]          back;
    logic [aqic_pkg::NUM_W-1:0] rem;
    logic                       bump3_next;
    logic [aqic_pkg::QUO_W-1:0] quo;
    logic [aqic_pkg::IDX_W-1:0] index_next;
    logic [aqic_pkg::CAT_W-1:0] category_next;

    always_comb
    begin
        // estimate is exact or one short
        prod      = PROD_W'(numer1_reg) * PROD_W'(recip1_reg);
        quo2_next = prod[aqic_pkg::NUM_W +: aqic_pkg::QUO_W];

        back       = BACK_W'(quo2_reg) * BACK_W'(den2_reg);
        rem        = numer2_reg - back[aqic_pkg::NUM_W-1:0];
        bump3_next = (rem >= aqic_pkg::NUM_W'(den2_reg));

        quo = quo3_reg + aqic_pkg::QUO_W'(bump3_reg);
        if (quo > SAT_AT)
            index_next = aqic_pkg::IDX_W'(aqic_pkg::IDX_MAX);
        else
            index_next = quo[aqic_pkg::IDX_W-1:0];

        // category from the unsaturated quotient
        if (quo <= CAT_B1)
            category_next = aqic_pkg::CAT_GOOD;
        else if (quo <= CAT_B2)
            category_next = aqic_pkg::CAT_MODERATE;
        else if (quo <= CAT_B3)
            category_next = aqic_pkg::CAT_SENSITIVE;
        else if (quo <= CAT_B4)
            category_next = aqic_pkg::CAT_UNHEALTHY;
        else if (quo <= CAT_B5)
            category_next = aqic_pkg::CAT_VERY_UNHEALTHY;
        else
            category_next = aqic_pkg::CAT_HAZARDOUS;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            numer1_reg <= numer;
            recip1_reg <= recip;
            den1_reg   <= den;
        end
        if (adv.s2)
        begin
            quo2_reg   <= quo2_next;
            numer2_reg <= numer1_reg;
            den2_reg   <= den1_reg;
        end
        if (adv.s3)
        begin
            quo3_reg  <= quo2_reg;
            bump3_reg <= bump3_next;
        end
        if (adv.so)
        begin
            index_reg    <= index_next;
            category_reg <= category_next;
        end
    end

    assign index    = index_reg;
    assign category = category_reg;

endmodule

`default_nettype wire

@@ hw/rtl/air_quality_index_classifier.sv @@
// Air quality index classifier.
// Input channel: in_valid / in_stall / in_data carry one reading of CO2, SO2,
//   NO2 and PM2.5 levels (4 fractional bits); a transfer happens on a rising
//   edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_data give, per pollutant, the
//   piecewise-linear index, its six-way category and the alert level. Exactly
//   one result per reading, in order.
// Config: cfg_we / cfg_index / cfg_wdata write one of the four high-alert
//   limits, chosen by cfg_index; write them only while no reading is in flight.
// Pipeline: four register stages (segment select, reciprocal multiply,
//   remainder check, output), passed by each reading in that order.
// Throughput: one reading per cycle while out_stall is low; each pollutant
//   has a reciprocal multiplier and a check multiplier, each in its own stage.
// Stall: each stage loads whenever its successor is empty or moving on, so
//   bubbles are squeezed out; in_stall rises only when all four stages hold
//   a reading and out_stall is high. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the default limits
//   (CO2 1000 ppm, SO2 40, NO2 25, PM2.5 15, all times 16).
`default_nettype none

module air_quality_index_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  aqic_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output aqic_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [aqic_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aqic_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // limit registers
    logic [aqic_pkg::CO2_W-1:0] co2_limit_reg;
    logic [aqic_pkg::GAS_W-1:0] so2_limit_reg;
    logic [aqic_pkg::GAS_W-1:0] no2_limit_reg;
    logic [aqic_pkg::GAS_W-1:0] pm25_limit_reg;

    // pipeline occupancy
    logic valid1_reg, valid2_reg, valid3_reg, valid_out_reg;
    logic rdy1, rdy2, rdy3, rdy_out;
    aqic_pkg::adv_t adv;

    // alert levels ride alongside the index lanes
    aqic_pkg::alerts_t alert1_next;
    aqic_pkg::alerts_t alert1_reg, alert2_reg, alert3_reg, alert_out_reg;

    // per-pollutant lanes, indexed by pollutant code
    logic [aqic_pkg::XS_W-1:0]  level_ext [4];
    logic [aqic_pkg::NUM_W-1:0] numer     [4];
    logic [aqic_pkg::REC_W-1:0] recip     [4];
    logic [aqic_pkg::DEN_W-1:0] den       [4];
    logic [aqic_pkg::IDX_W-1:0] index     [4];
    logic [aqic_pkg::CAT_W-1:0] category  [4];

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co2_limit_reg  <= aqic_pkg::CO2_LIMIT_RST;
            so2_limit_reg  <= aqic_pkg::SO2_LIMIT_RST;
            no2_limit_reg  <= aqic_pkg::NO2_LIMIT_RST;
            pm25_limit_reg <= aqic_pkg::PM25_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aqic_pkg::CFG_CO2_LIMIT:  co2_limit_reg  <= cfg_wdata;
                aqic_pkg::CFG_SO2_LIMIT:  so2_limit_reg  <= cfg_wdata[aqic_pkg::GAS_W-1:0];
                aqic_pkg::CFG_NO2_LIMIT:  no2_limit_reg  <= cfg_wdata[aqic_pkg::GAS_W-1:0];
                aqic_pkg::CFG_PM25_LIMIT: pm25_limit_reg <= cfg_wdata[aqic_pkg::GAS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: a stage takes new data when empty or when its
    // contents move on in the same cycle
    // ---------------------------------------------------------------
    always_comb
    begin
        rdy_out = !valid_out_reg || !out_stall;
        rdy3    = !valid3_reg || rdy_out;
        rdy2    = !valid2_reg || rdy3;
        rdy1    = !valid1_reg || rdy2;

        adv.s1 = rdy1 && in_valid;
        adv.s2 = rdy2 && valid1_reg;
        adv.s3 = rdy3 && valid2_reg;
        adv.so = rdy_out && valid3_reg;
    end

    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                valid1_reg <= in_valid;
            if (rdy2)
                valid2_reg <= valid1_reg;
            if (rdy3)
                valid3_reg <= valid2_reg;
            if (rdy_out)
                valid_out_reg <= valid3_reg;
        end
    end

    // ---------------------------------------------------------------
    // alert levels: limit tests first, so a low limit still gives high
    // ---------------------------------------------------------------
    always_comb
    begin
        if (in_data.co2_level > co2_limit_reg)
            alert1_next.co2 = aqic_pkg::CO2_ALERT_HIGH;
        else if (in_data.co2_level > aqic_pkg::CO2_MED_ABOVE)
            alert1_next.co2 = aqic_pkg::CO2_ALERT_MEDIUM;
        else if (in_data.co2_level >= aqic_pkg::CO2_LOW_FROM)
            alert1_next.co2 = aqic_pkg::CO2_ALERT_LOW;
        else
            alert1_next.co2 = aqic_pkg::CO2_ALERT_VERY_LOW;

        if (in_data.so2_level > so2_limit_reg)
            alert1_next.so2 = aqic_pkg::GAS_ALERT_HIGH;
        else if (in_data.so2_level >= aqic_pkg::SO2_MED_FROM)
            alert1_next.so2 = aqic_pkg::GAS_ALERT_MEDIUM;
        else
            alert1_next.so2 = aqic_pkg::GAS_ALERT_LOW;

        if (in_data.no2_level > no2_limit_reg)
            alert1_next.no2 = aqic_pkg::GAS_ALERT_HIGH;
        else if (in_data.no2_level >= aqic_pkg::NO2_MED_FROM)
            alert1_next.no2 = aqic_pkg::GAS_ALERT_MEDIUM;
        else
            alert1_next.no2 = aqic_pkg::GAS_ALERT_LOW;

        if (in_data.pm25_level > pm25_limit_reg)
            alert1_next.pm25 = aqic_pkg::GAS_ALERT_HIGH;
        else if (in_data.pm25_level >= aqic_pkg::PM25_MED_FROM)
            alert1_next.pm25 = aqic_pkg::GAS_ALERT_MEDIUM;
        else
            alert1_next.pm25 = aqic_pkg::GAS_ALERT_LOW;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
            alert1_reg <= alert1_next;
        if (adv.s2)
            alert2_reg <= alert1_reg;
        if (adv.s3)
            alert3_reg <= alert2_reg;
        if (adv.so)
            alert_out_reg <= alert3_reg;
    end

    // ---------------------------------------------------------------
    // index lanes
    // ---------------------------------------------------------------
    assign level_ext[aqic_pkg::POL_CO2]  = in_data.co2_level;
    assign level_ext[aqic_pkg::POL_SO2]  = aqic_pkg::XS_W'(in_data.so2_level);
    assign level_ext[aqic_pkg::POL_NO2]  = aqic_pkg::XS_W'(in_data.no2_level);
    assign level_ext[aqic_pkg::POL_PM25] = aqic_pkg::XS_W'(in_data.pm25_level);

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        aqic_seg #(
            .KIND (aqic_pkg::pollutant_t'(g))
        ) u_seg (
            .level (level_ext[g]),
            .numer (numer[g]),
            .recip (recip[g]),
            .den   (den[g])
        );

        aqic_div u_div (
            .clk      (clk),
            .adv      (adv),
            .numer    (numer[g]),
            .recip    (recip[g]),
            .den      (den[g]),
            .index    (index[g]),
            .category (category[g])
        );
    end

    // ---------------------------------------------------------------
    // output
    // ---------------------------------------------------------------
    assign out_valid = valid_out_reg;

    always_comb
    begin
        out_data.co2_index        = index[aqic_pkg::POL_CO2];
        out_data.so2_index        = index[aqic_pkg::POL_SO2];
        out_data.no2_index        = index[aqic_pkg::POL_NO2];
        out_data.pm25_index       = index[aqic_pkg::POL_PM25];
        out_data.co2_category     = category[aqic_pkg::POL_CO2];
        out_data.so2_category     = category[aqic_pkg::POL_SO2];
        out_data.no2_category     = category[aqic_pkg::POL_NO2];
        out_data.pm25_category    = category[aqic_pkg::POL_PM25];
        out_data.co2_alert_level  = alert_out_reg.co2;
        out_data.so2_alert_level  = alert_out_reg.so2;
        out_data.no2_alert_level  = alert_out_reg.no2;
        out_data.pm25_alert_level = alert_out_reg.pm25;
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // input held off only with every stage full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid1_reg && valid2_reg && valid3_reg && valid_out_reg))
        else $error("input stalled with a free pipeline stage");

    // taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid3_reg) |=> !out_valid)
        else $error("result repeated after transfer");

    // indices never pass the top-segment constants
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_data.co2_index <= aqic_pkg::IDX_W'(101 * aqic_pkg::SCALE)) &&
            (out_data.so2_index <= aqic_pkg::IDX_W'(151 * aqic_pkg::SCALE)) &&
            (out_data.no2_index <= aqic_pkg::IDX_W'(151 * aqic_pkg::SCALE)) &&
            (out_data.pm25_index <= aqic_pkg::IDX_W'(151 * aqic_pkg::SCALE)))
        else $error("index out of range");

endmodule

`default_nettype wire

@@ tb/air_quality_index_classifier_tb.sv @@
`timescale 1ns / 100ps

module air_quality_index_classifier_tb;

    import aqic_pkg::*;

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT = 200000;   // far beyond the slowest legal run
    localparam int ITEMS_PER_HALF = 158;   // two halves per phase, six phases
    localparam int NUM_PHASES = 6;
    localparam int CO2_MASK = (1 << CO2_W) - 1;
    localparam int GAS_MASK = (1 << GAS_W) - 1;

    // how the limit registers are set at the start of a phase
    typedef enum int {
        LIM_KEEP,
        LIM_RANDOM_IN_RANGE,
        LIM_ZERO,
        LIM_ALL_ONES,
        LIM_BELOW_MEDIUM,
        LIM_RANDOM_FULL
    } limit_plan_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the alert limits, kept in step with each register write
    logic [CO2_W-1:0] co2_limit  = 18'd16000;
    logic [GAS_W-1:0] so2_limit  = 14'd640;
    logic [GAS_W-1:0] no2_limit  = 14'd400;
    logic [GAS_W-1:0] pm25_limit = 14'd240;

    in_item_t  readings_to_send[$];   // filled by the stimulus, drained by the driver
    out_item_t aqi_expected[$];       // predicted results, oldest first

    int send_gap_pct   = 0;           // chance per cycle that the sender idles
    int sink_stall_pct = 0;           // chance per cycle that the receiver stalls
    int mismatches     = 0;
    int cycles         = 0;

    always #5 clk = ~clk;

    air_quality_index_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Index predictor
    // ------------------------------------------------------------------

    // base*S + 50*(xs - off)/den, nearest, halves up; floored at zero so the
    // dip in the gap just past a breakpoint never goes negative
    function automatic longint seg_line(input longint base, input longint xs,
                                        input longint off, input longint den);
        longint num;
        num = base * SCALE * den + 50 * (xs - off);
        if (num < 0)
            num = 0;
        return (num + den / 2) / den;
    endfunction

    function automatic longint aqi_of(input pollutant_t p, input longint x);
        longint t;
        longint idx;
        t = 10 * x;                      // PM2.5 breakpoints sit on tenths
        case (p)
            POL_CO2:
                if (x <= 800 * SCALE)       idx = seg_line(0, x, 0, 800);
                else if (x <= 1000 * SCALE) idx = seg_line(50, x, 801 * SCALE, 199);
                else                        idx = 101 * SCALE;
            POL_SO2:
                if (x <= 35 * SCALE)        idx = seg_line(0, x, 0, 35);
                else if (x <= 75 * SCALE)   idx = seg_line(50, x, 36 * SCALE, 39);
                else if (x <= 185 * SCALE)  idx = seg_line(100, x, 76 * SCALE, 109);
                else                        idx = 151 * SCALE;
            POL_NO2:
                if (x <= 53 * SCALE)        idx = seg_line(0, x, 0, 53);
                else if (x <= 100 * SCALE)  idx = seg_line(50, x, 54 * SCALE, 46);
                else if (x <= 360 * SCALE)  idx = seg_line(100, x, 101 * SCALE, 259);
                else                        idx = 151 * SCALE;
            default:
                if (x <= 12 * SCALE)        idx = seg_line(0, t, 0, 120);
                else if (t <= 354 * SCALE)  idx = seg_line(50, t, 121 * SCALE, 233);
                else if (t <= 554 * SCALE)  idx = seg_line(100, t, 355 * SCALE, 199);
                else                        idx = 151 * SCALE;
        endcase
        return idx;
    endfunction

    // category is taken from the index before saturation
    function automatic logic [CAT_W-1:0] category_of(input longint idx);
        if (idx <= 50 * SCALE)  return CAT_GOOD;
        if (idx <= 100 * SCALE) return CAT_MODERATE;
        if (idx <= 150 * SCALE) return CAT_SENSITIVE;
        if (idx <= 200 * SCALE) return CAT_UNHEALTHY;
        if (idx <= 300 * SCALE) return CAT_VERY_UNHEALTHY;
        return CAT_HAZARDOUS;
    endfunction

    function automatic logic [IDX_W-1:0] sat_index(input longint idx);
        if (idx > (1 << IDX_W) - 1)
            return '1;
        return idx[IDX_W-1:0];
    endfunction

    // limit test first: a limit under the medium threshold still gives high
    function automatic logic [ALERT_W-1:0] gas_alert(input longint x, input longint limit,
                                                     input longint med_from);
        if (x > limit)     return GAS_ALERT_HIGH;
        if (x >= med_from) return GAS_ALERT_MEDIUM;
        return GAS_ALERT_LOW;
    endfunction

    function automatic out_item_t classify_reading(input in_item_t r);
        out_item_t o;
        longint    i_co2;
        longint    i_so2;
        longint    i_no2;
        longint    i_pm;
        i_co2 = aqi_of(POL_CO2, r.co2_level);
        i_so2 = aqi_of(POL_SO2, r.so2_level);
        i_no2 = aqi_of(POL_NO2, r.no2_level);
        i_pm  = aqi_of(POL_PM25, r.pm25_level);
        o.co2_index     = sat_index(i_co2);
        o.so2_index     = sat_index(i_so2);
        o.no2_index     = sat_index(i_no2);
        o.pm25_index    = sat_index(i_pm);
        o.co2_category  = category_of(i_co2);
        o.so2_category  = category_of(i_so2);
        o.no2_category  = category_of(i_no2);
        o.pm25_category = category_of(i_pm);
        if (r.co2_level > co2_limit)
            o.co2_alert_level = CO2_ALERT_HIGH;
        else if (r.co2_level > 800 * SCALE)
            o.co2_alert_level = CO2_ALERT_MEDIUM;
        else if (r.co2_level >= 400 * SCALE)
            o.co2_alert_level = CO2_ALERT_LOW;
        else
            o.co2_alert_level = CO2_ALERT_VERY_LOW;
        o.so2_alert_level  = gas_alert(r.so2_level, so2_limit, 21 * SCALE);
        o.no2_alert_level  = gas_alert(r.no2_level, no2_limit, 14 * SCALE);
        o.pm25_alert_level = gas_alert(r.pm25_level, pm25_limit, 8 * SCALE);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the next reading once the previous transfer is done;
    // valid stays high across back-to-back transfers, payload held on stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                aqi_expected.push_back(classify_reading(in_data));
            if (readings_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= readings_to_send.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each output transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input out_item_t e, input out_item_t a);
        check_field("co2_index", e.co2_index, a.co2_index);
        check_field("so2_index", e.so2_index, a.so2_index);
        check_field("no2_index", e.no2_index, a.no2_index);
        check_field("pm25_index", e.pm25_index, a.pm25_index);
        check_field("co2_category", e.co2_category, a.co2_category);
        check_field("so2_category", e.so2_category, a.so2_category);
        check_field("no2_category", e.no2_category, a.no2_category);
        check_field("pm25_category", e.pm25_category, a.pm25_category);
        check_field("co2_alert_level", e.co2_alert_level, a.co2_alert_level);
        check_field("so2_alert_level", e.so2_alert_level, a.so2_alert_level);
        check_field("no2_alert_level", e.no2_alert_level, a.no2_alert_level);
        check_field("pm25_alert_level", e.pm25_alert_level, a.pm25_alert_level);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (aqi_expected.size() == 0)
                begin
                    $error("out_data: result transfer with no reading outstanding");
                    mismatches++;
                end
                else
                    check_result(aqi_expected.pop_front(), out_data);
            end
            out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** air_quality_index_classifier: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // interesting raw levels per pollutant: alert thresholds and segment edges
    function automatic int breakpoint_of(input pollutant_t p, input int k);
        case (p)
            POL_CO2:  case (k) 0: return 400 * SCALE; 1: return 800 * SCALE;
                          2: return 801 * SCALE; 3: return 1000 * SCALE;
                          default: return 160000; endcase
            POL_SO2:  case (k) 0: return 21 * SCALE; 1: return 35 * SCALE;
                          2: return 75 * SCALE; 3: return 185 * SCALE;
                          default: return 76 * SCALE; endcase
            POL_NO2:  case (k) 0: return 14 * SCALE; 1: return 53 * SCALE;
                          2: return 100 * SCALE; 3: return 360 * SCALE;
                          default: return 101 * SCALE; endcase
            default:  case (k) 0: return 8 * SCALE; 1: return 12 * SCALE;
                          2: return 194; 3: return 566;
                          default: return 886; endcase
        endcase
    endfunction

    // in-range values for three draws in eight, a share clustered on edges and the limit,
    // some at either extreme and some over the full field width
    function automatic int random_level(input pollutant_t p, input int mask,
                                        input int range_hi, input int limit);
        int v;
        case ($urandom_range(0, 7))
            0:       v = $urandom & mask;
            1:       v = $urandom_range(0, 1) ? mask : 0;
            2, 3:    v = breakpoint_of(p, $urandom_range(0, 4)) + $urandom_range(0, 48) - 24;
            4:       v = limit + $urandom_range(0, 6) - 3;
            default: v = $urandom_range(0, range_hi);
        endcase
        if (v < 0)
            v = 0;
        if (v > mask)
            v = mask;
        return v;
    endfunction

    task automatic queue_random_readings(input int count);
        in_item_t r;
        repeat (count)
        begin
            r.co2_level  = CO2_W'(random_level(POL_CO2, CO2_MASK, 160000, co2_limit));
            r.so2_level  = GAS_W'(random_level(POL_SO2, GAS_MASK, 16000, so2_limit));
            r.no2_level  = GAS_W'(random_level(POL_NO2, GAS_MASK, 16000, no2_limit));
            r.pm25_level = GAS_W'(random_level(POL_PM25, GAS_MASK, 16000, pm25_limit));
            readings_to_send.push_back(r);
        end
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic wait_drained;
        @(negedge clk);
        while (readings_to_send.size() != 0 || in_valid || aqi_expected.size() != 0)
            @(negedge clk);
    endtask

    // register write, leaving cfg_we high for the caller to lower; the shadow copy keeps only the field's bits
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CO2_LIMIT:  co2_limit  = val;
            CFG_SO2_LIMIT:  so2_limit  = val[GAS_W-1:0];
            CFG_NO2_LIMIT:  no2_limit  = val[GAS_W-1:0];
            CFG_PM25_LIMIT: pm25_limit = val[GAS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_limit(input limit_plan_t plan,
                                                         input int range_hi,
                                                         input int med_from);
        case (plan)
            LIM_RANDOM_IN_RANGE: return CFG_DATA_W'($urandom_range(0, range_hi));
            LIM_ZERO:            return '0;
            LIM_ALL_ONES:        return '1;
            LIM_BELOW_MEDIUM:    return CFG_DATA_W'($urandom_range(0, med_from - 1));
            default:             return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic apply_limits(input limit_plan_t plan);
        if (plan != LIM_KEEP)
        begin
            write_limit(CFG_CO2_LIMIT, pick_limit(plan, 160000, 400 * SCALE));
            write_limit(CFG_SO2_LIMIT, pick_limit(plan, 16000, 21 * SCALE));
            write_limit(CFG_NO2_LIMIT, pick_limit(plan, 16000, 14 * SCALE));
            write_limit(CFG_PM25_LIMIT, pick_limit(plan, 16000, 8 * SCALE));
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed edges at the reset limits, then six phases
    // of random readings, each under a new idling pattern and, from the
    // second on, new limits

    // segment edges, gap dips just past a breakpoint, alert thresholds,
    // the reset limits and both extremes of every field
    int dir_co2[13]  = '{0, 6399, 6400, 12800, 12801, 12815, 12816,
                         16000, 16001, 16016, 16017, 160000, 262143};
    int dir_so2[13]  = '{0, 335, 336, 560, 561, 575, 576,
                         640, 641, 1200, 2960, 2961, 16383};
    int dir_no2[13]  = '{0, 223, 224, 400, 401, 848, 849,
                         863, 1600, 5760, 5761, 16000, 16383};
    int dir_pm25[13] = '{0, 127, 128, 192, 193, 240, 241,
                         566, 567, 886, 887, 16000, 16383};

    limit_plan_t phase_plan[NUM_PHASES] = '{LIM_KEEP, LIM_RANDOM_IN_RANGE, LIM_ZERO,
                                            LIM_ALL_ONES, LIM_BELOW_MEDIUM,
                                            LIM_RANDOM_FULL};

    initial
    begin : stimulus
        in_item_t r;
        for (int i = 0; i < 13; i++)
        begin
            r.co2_level  = CO2_W'(dir_co2[i]);
            r.so2_level  = GAS_W'(dir_so2[i]);
            r.no2_level  = GAS_W'(dir_no2[i]);
            r.pm25_level = GAS_W'(dir_pm25[i]);
            readings_to_send.push_back(r);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // limits change only with nothing in flight
            wait_drained();
            apply_limits(phase_plan[ph]);
            @(negedge clk);
            case (ph % 3)
                0:       begin send_gap_pct = 17; sink_stall_pct = 68; end
                1:       begin send_gap_pct = 68; sink_stall_pct = 17; end
                default: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
            endcase
            queue_random_readings(ITEMS_PER_HALF);
            // mid-phase pause: pipeline empties while the receiver keeps stalling at its phase's rate
            wait_drained();
            queue_random_readings(ITEMS_PER_HALF);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** air_quality_index_classifier: PASSED **");
        else
            $display("** air_quality_index_classifier: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/aqic_pkg.sv
hw/rtl/aqic_seg.sv
hw/rtl/aqic_div.sv
hw/rtl/air_quality_index_classifier.sv
tb/air_quality_index_classifier_tb.sv
